[src/mfs_pkg.sv]
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared sizes, codes and types of the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int ID_BITS    = 8;
  localparam int NUM_LEVELS = 3;

  localparam int PTR_W   = $clog2(MAX_PROCS);
  localparam int CNT_W   = $clog2(MAX_PROCS + 1);
  localparam int SLOTS   = NUM_LEVELS * MAX_PROCS;
  localparam int ADDR_W  = $clog2(SLOTS);
  // ids arrive on an 8-bit port, so no stored bit above 8 is ever set
  localparam int ID_W    = (ID_BITS < 8) ? ID_BITS : 8;
  localparam int AGE_W   = 16;
  localparam int ENTRY_W = ID_W + AGE_W;
  localparam int LVL_W   = 2;

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_NEXT = 2'd2;

  localparam logic [1:0] CFG_AGE_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_SLICE_HIGH = 2'd1;
  localparam logic [1:0] CFG_SLICE_LOW  = 2'd2;

  localparam logic [LVL_W-1:0] LVL_FCFS = 2'd0;
  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;

  localparam logic [AGE_W-1:0] AGE_LIMIT_RST  = 16'd1000;
  localparam logic [3:0]       SLICE_HIGH_RST = 4'd4;
  localparam logic [3:0]       SLICE_LOW_RST  = 4'd1;
  localparam logic [AGE_W-1:0] AGE_SAT        = '1;
  localparam logic signed [4:0] SLICE_FOREVER = -5'sd1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TRD  = 5'b00010,
    S_TWR  = 5'b00100,
    S_POP  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic              accepted;
    logic              found;
    logic [ID_W-1:0]   id;
    logic [LVL_W-1:0]  level;
    logic signed [4:0] slice;
  } result_t;

endpackage

[src/multilevel_feedback_scheduler.sv]
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Three-level feedback queue scheduler: level 0 FCFS, levels 1 and 2 round
// robin, with aging promotion of entries one level up on each tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | kind, process_id, priority_req
//  out     | output    | out_valid/ out_ready | accepted, found, chosen_id,
//          |           |                      | chosen_level, time_slice
//  cfg     | input     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
//  Add: accept, then result load. Next: accept, entry RAM read, then result
//  load. Tick: levels 1 and 2 are walked in turn; the entry RAM is read, then
//  written, once per entry. A result waiting on out_ready does not block the
//  next item; the following result waits in its load state. Reset clears all
//  counts and heads and sets state, valid and config registers to defaults;
//  no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler
  import mfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [7:0]        process_id,
  input  logic [1:0]        priority_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              accepted,
  output logic              found,
  output logic [7:0]        chosen_id,
  output logic [1:0]        chosen_level,
  output logic signed [4:0] time_slice,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  state_t           state;
  logic [PTR_W-1:0] level_head  [NUM_LEVELS];
  logic [CNT_W-1:0] level_count [NUM_LEVELS];
  logic [CNT_W-1:0] total_count;
  logic [AGE_W-1:0] age_limit;
  logic [3:0]       slice_high;
  logic [3:0]       slice_low;
  logic [LVL_W-1:0] lvl;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] kept;
  result_t          res;

  logic               in_fire;
  logic               add_ok;
  logic               next_any;
  logic [LVL_W-1:0]   next_lvl;
  logic [LVL_W-1:0]   lvl_low;
  logic [ID_W-1:0]    rd_id;
  logic [AGE_W-1:0]   rd_age;
  logic [AGE_W-1:0]   age_inc;
  logic               promote;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // ring slot of position p in level l
  function automatic logic [ADDR_W-1:0] slot_addr(logic [LVL_W-1:0] l,
                                                  logic [PTR_W-1:0] h,
                                                  logic [CNT_W-1:0] p);
    logic [CNT_W:0]   sum;
    logic [PTR_W-1:0] ring;
    sum = (CNT_W+1)'(h) + (CNT_W+1)'(p);
    if (sum >= (CNT_W+1)'(MAX_PROCS)) begin
      sum = sum - (CNT_W+1)'(MAX_PROCS);
    end
    ring = sum[PTR_W-1:0];
    return ADDR_W'(l) * ADDR_W'(MAX_PROCS) + ADDR_W'(ring);
  endfunction

  function automatic logic signed [4:0] slice_of(logic [LVL_W-1:0] l,
                                                 logic [3:0] hi, logic [3:0] lo);
    logic signed [4:0] s;
    case (l)
      LVL_FCFS: s = SLICE_FOREVER;
      LVL_HIGH: s = $signed({1'b0, hi});
      default:  s = $signed({1'b0, lo});
    endcase
    return s;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  assign add_ok = (priority_req != 2'd3) && (total_count < CNT_W'(MAX_PROCS)) &&
                  (level_count[priority_req] < CNT_W'(MAX_PROCS));

  always_comb begin
    next_any = 1'b1;
    next_lvl = LVL_FCFS;
    if (level_count[0] != '0) begin
      next_lvl = LVL_FCFS;
    end else if (level_count[1] != '0) begin
      next_lvl = LVL_HIGH;
    end else if (level_count[2] != '0) begin
      next_lvl = LVL_LOW;
    end else begin
      next_any = 1'b0;
    end
  end

  assign lvl_low = lvl - 2'd1;
  assign rd_id   = ram_rdata[ENTRY_W-1 -: ID_W];
  assign rd_age  = ram_rdata[AGE_W-1:0];
  assign age_inc = (rd_age == AGE_SAT) ? rd_age : rd_age + 1'b1;
  assign promote = (age_inc >= age_limit);

  // kept entries compact toward the head in place: writes never pass reads
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        if (in_fire && kind == KIND_ADD && add_ok) begin
          ram_we    = 1'b1;
          ram_waddr = slot_addr(priority_req, level_head[priority_req],
                                level_count[priority_req]);
          ram_wdata = {process_id[ID_W-1:0], {AGE_W{1'b0}}};
        end else if (in_fire && kind == KIND_NEXT && next_any) begin
          ram_re    = 1'b1;
          ram_raddr = slot_addr(next_lvl, level_head[next_lvl], '0);
        end
      end
      S_TRD: begin
        if (pos != level_count[lvl]) begin
          ram_re    = 1'b1;
          ram_raddr = slot_addr(lvl, level_head[lvl], pos);
        end
      end
      S_TWR: begin
        ram_we = 1'b1;
        if (promote) begin
          ram_waddr = slot_addr(lvl_low, level_head[lvl_low], level_count[lvl_low]);
          ram_wdata = {rd_id, {AGE_W{1'b0}}};
        end else begin
          ram_waddr = slot_addr(lvl, level_head[lvl], kept);
          ram_wdata = {rd_id, age_inc};
        end
      end
      default: ;
    endcase
  end

  mfs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      total_count <= '0;
      out_valid   <= 1'b0;
      age_limit   <= AGE_LIMIT_RST;
      slice_high  <= SLICE_HIGH_RST;
      slice_low   <= SLICE_LOW_RST;
      lvl         <= LVL_HIGH;
      pos         <= '0;
      kept        <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        level_head[i]  <= '0;
        level_count[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_AGE_LIMIT:  age_limit  <= cfg_data;
          CFG_SLICE_HIGH: slice_high <= cfg_data[3:0];
          CFG_SLICE_LOW:  slice_low  <= cfg_data[3:0];
          default: ;
        endcase
      end

      // drop valid, unless the load state refills the register this cycle
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (kind)
              KIND_ADD: begin
                res <= '{accepted: add_ok, found: 1'b0, id: '0, level: '0,
                         slice: '0};
                if (add_ok) begin
                  level_count[priority_req] <= level_count[priority_req] + 1'b1;
                  total_count               <= total_count + 1'b1;
                end
                state <= S_EMIT;
              end
              KIND_NEXT: begin
                res <= '{accepted: 1'b0, found: next_any, id: '0, level: next_lvl,
                         slice: next_any ? slice_of(next_lvl, slice_high, slice_low)
                                         : 5'sd0};
                if (next_any) begin
                  if (level_head[next_lvl] == PTR_W'(MAX_PROCS - 1)) begin
                    level_head[next_lvl] <= '0;
                  end else begin
                    level_head[next_lvl] <= level_head[next_lvl] + 1'b1;
                  end
                  level_count[next_lvl] <= level_count[next_lvl] - 1'b1;
                  total_count           <= total_count - 1'b1;
                  state                 <= S_POP;
                end else begin
                  state <= S_EMIT;
                end
              end
              KIND_TICK: begin
                lvl   <= LVL_HIGH;
                pos   <= '0;
                kept  <= '0;
                state <= S_TRD;
              end
              default: ;
            endcase
          end
        end
        S_TRD: begin
          if (pos == level_count[lvl]) begin
            level_count[lvl] <= kept;
            if (lvl == LVL_HIGH) begin
              lvl  <= LVL_LOW;
              pos  <= '0;
              kept <= '0;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_TWR;
          end
        end
        S_TWR: begin
          pos <= pos + 1'b1;
          if (promote) begin
            level_count[lvl_low] <= level_count[lvl_low] + 1'b1;
          end else begin
            kept <= kept + 1'b1;
          end
          state <= S_TRD;
        end
        S_POP: begin
          res.id <= rd_id;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          // hold the result until the output register frees up
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            accepted     <= res.accepted;
            found        <= res.found;
            chosen_id    <= 8'(res.id);
            chosen_level <= res.level;
            time_slice   <= res.slice;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // level counts lag during a tick pass, so check outside of it
  a_total_is_sum: assert property (@(posedge clk) disable iff (rst)
    (state != S_TRD && state != S_TWR)
    |-> total_count == level_count[0] + level_count[1] + level_count[2])
    else $error("total count differs from the sum of level counts");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total_count <= CNT_W'(MAX_PROCS))
    else $error("total count above capacity");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRD || state == S_TWR) |-> kept <= pos)
    else $error("compaction write ran ahead of the read position");

  a_next_pops: assert property (@(posedge clk) disable iff (rst)
    in_fire && kind == KIND_NEXT && total_count != '0
    |=> total_count == $past(total_count) - 1'b1)
    else $error("next item on a non-empty scheduler did not pop an entry");
`endif

endmodule

[src/mfs_ram.sv]
// ----------------------------------------------------------------------------
// mfs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
